>>> design/exif_ifd0_orientation_scan_core_assert.svh
// Assertion shorthands for the orientation scan core.
// Each expects signals named clk and rst in the scope where it is used.
`ifndef EXIF_IFD0_ORIENTATION_SCAN_CORE_ASSERT_SVH
`define EXIF_IFD0_ORIENTATION_SCAN_CORE_ASSERT_SVH

// Plain property, checked on every edge out of reset.
`define EIOS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define EIOS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> design/eios_pkg.sv
package eios_pkg;

  // Default sizing
  localparam int MAX_ENTRIES_DEF = 256;
  localparam int MAX_LEN_DEF     = 65536;

  // Layout of the payload
  localparam int unsigned ID_LEN    = 6;
  localparam int unsigned HDR_LEN   = 8;
  localparam int unsigned ENTRY_LEN = 12;

  // Tags, kinds and header codes
  localparam logic [15:0] TAG_ORIENT = 16'h0112;
  localparam logic [15:0] TAG_GPS    = 16'h8825;
  localparam logic [15:0] KIND_SHORT = 16'd3;
  localparam logic [15:0] KIND_LONG  = 16'd4;
  localparam logic [15:0] MAGIC      = 16'd42;
  localparam logic [7:0]  CHAR_I     = 8'h49;
  localparam logic [7:0]  CHAR_M     = 8'h4D;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_EXIF  = 2'd1,
    STATUS_MALFORMED = 2'd2
  } status_t;

  // One input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // One result item
  typedef struct packed {
    status_t    status;
    logic       valid_res;
    logic       order_mm;
    logic [3:0] orientation;
    logic       has_gps;
    logic       has_next_ifd;
    logic [8:0] ifd_entries;
  } result_t;

  // Identifier byte at a given position ("Exif" then two zeros)
  function automatic logic [7:0] exif_id_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h45;
      3'd1:    val = 8'h78;
      3'd2:    val = 8'h69;
      3'd3:    val = 8'h66;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // Raw words hold the first byte highest; swap for little-endian order
  function automatic logic [15:0] ord16(input logic [15:0] raw, input logic big);
    return big ? raw : {raw[7:0], raw[15:8]};
  endfunction

  function automatic logic [31:0] ord32(input logic [31:0] raw, input logic big);
    return big ? raw : {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
  endfunction

endpackage

>>> design/exif_ifd0_orientation_scan_core.sv
// Exif IFD0 orientation scanner.
// Input channel s_*: one APP1 payload byte per item, starting at the "Exif"
// identifier, with s_tlast on the final byte. Output channel m_*: one result
// per payload, issued for the byte marked last (status, byte order,
// orientation, GPS and next-IFD flags, entry count).
// Throughput: one byte per cycle while no last byte waits on a pending
// result, set by the single scan stage that updates the header, directory
// and entry state for each byte. An accepted byte is scanned from the input
// register; the result of a last byte is registered in the output register
// as that byte is scanned and is then shown on m_tvalid.
// Reset (rst, synchronous) empties both registers and clears the scan state;
// the state also returns to reset after every last byte, so the next payload
// may follow at once.
// Stall: a waiting result holds in the output register while non-last bytes
// keep flowing; only a further last byte waits in the input register, which
// then drops s_tready until m_tready takes the pending result.
// Bytes past MAX_LEN are ignored; MAX_ENTRIES caps the accepted entry count.
`include "exif_ifd0_orientation_scan_core_assert.svh"

module exif_ifd0_orientation_scan_core #(
  parameter int MAX_ENTRIES = eios_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_LEN     = eios_pkg::MAX_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // status[1:0], valid_res, order_mm, orientation[3:0],
                                 // has_gps, has_next_ifd, ifd_entries[8:0], zero pad
);
  import eios_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    fire;
  result_t result;
  logic    out_ok;
  logic    last_blocked;

  // Scan the held byte unless it is a last byte and the result slot stays full
  assign fire = in_valid && (!in_item.last_byte || !m_tvalid || m_tready);

  eios_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .fire     (fire),
    .in_valid (in_valid),
    .in_item  (in_item)
  );

  eios_scan #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_LEN     (MAX_LEN)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_item),
    .result (result)
  );

  eios_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (fire && in_item.last_byte),
    .result   (result),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Checks
  assign out_ok       = m_tvalid && (m_tdata[1:0] == STATUS_OK);
  assign last_blocked = in_valid && in_item.last_byte && m_tvalid && !m_tready;

  `EIOS_ASSERT_IMP(a_ok_means_valid, m_tvalid, out_ok == m_tdata[2], "valid flag wrong")
  `EIOS_ASSERT_IMP(a_fail_clear, m_tvalid && !out_ok, m_tdata[18:4] == 15'd0, "failure fields")
  `EIOS_ASSERT_IMP(a_orient_range, m_tvalid, m_tdata[7:4] <= 4'd8, "orientation out of range")
  `EIOS_ASSERT_IMP(a_stall_only_on_last, !s_tready, last_blocked, "input stalled without cause")

endmodule

>>> design/eios_in_reg.sv
module eios_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // data_byte
  input  logic          s_tlast,   // last_byte
  input  logic          fire,
  output logic          in_valid,
  output eios_pkg::item_t in_item
);
  import eios_pkg::*;

  logic load;

  // Free when empty or when the held item moves on this cycle
  assign s_tready = !in_valid || fire;
  assign load     = s_tvalid && s_tready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (load) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (load) begin
      in_item.data_byte <= s_tdata;
      in_item.last_byte <= s_tlast;
    end
  end

endmodule

>>> design/eios_scan.sv
module eios_scan #(
  parameter int MAX_ENTRIES = eios_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_LEN     = eios_pkg::MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  eios_pkg::item_t   item,
  output eios_pkg::result_t result
);
  import eios_pkg::*;

  localparam int PW = $clog2(MAX_LEN + 1);
  localparam logic [PW-1:0] LenMax = PW'(MAX_LEN);
  localparam logic [PW-1:0] IdLen  = PW'(ID_LEN);
  localparam logic [PW-1:0] HdrLen = PW'(HDR_LEN);
  localparam logic [16:0]   EntMax = 17'(MAX_ENTRIES);

  // Scan state
  logic [PW-1:0] pos, pos_next;
  logic          order_big, order_big_next;
  logic [31:0]   field_shift, field_shift_next;
  logic [31:0]   ifd_offset, ifd_offset_next;
  logic [15:0]   entries, entries_next;
  logic [63:0]   entry_fields, entry_fields_next;
  logic [3:0]    found_orient, found_orient_next;
  logic [3:0]    flags, flags_next;
  logic [34:0]   end_pos, end_pos_next;
  logic          end_valid, end_valid_next;
  logic [3:0]    rel, rel_next;

  logic [7:0]    b;
  logic [PW-1:0] t;
  logic [34:0]   t_ext;
  logic [34:0]   base;
  logic [31:0]   fs_shift;
  logic [15:0]   cnt_new;
  logic [15:0]   tag;
  logic [15:0]   kind;
  logic [31:0]   n_vals;
  logic [31:0]   val;
  logic          val_ok;
  logic [PW-1:0] tlen;
  logic [34:0]   tlen_ext;

  assign b        = item.data_byte;
  assign t        = pos - IdLen;
  assign t_ext    = 35'(t);
  assign base     = 35'(ifd_offset);
  assign fs_shift = {field_shift[23:0], b};
  assign cnt_new  = ord16({field_shift[7:0], b}, order_big);

  // Decode a finished entry
  always_comb begin
    tag    = ord16(entry_fields[63:48], order_big);
    kind   = ord16(entry_fields[47:32], order_big);
    n_vals = ord32(entry_fields[31:0], order_big);
    val_ok = 1'b0;
    val    = 32'd0;
    if (kind == KIND_SHORT) begin
      val    = 32'(ord16(fs_shift[31:16], order_big));
      val_ok = 1'b1;
    end else if (kind == KIND_LONG) begin
      val    = ord32(fs_shift, order_big);
      val_ok = 1'b1;
    end
  end

  // Advance the scan by one byte
  always_comb begin
    pos_next          = pos;
    order_big_next    = order_big;
    field_shift_next  = field_shift;
    ifd_offset_next   = ifd_offset;
    entries_next      = entries;
    entry_fields_next = entry_fields;
    found_orient_next = found_orient;
    flags_next        = flags;
    end_pos_next      = end_pos;
    end_valid_next    = end_valid;
    rel_next          = rel;
    if (pos < LenMax) begin
      pos_next = pos + 1'b1;
      if (pos < IdLen) begin
        if (b != exif_id_byte(pos[2:0])) begin
          flags_next[0] = 1'b1;
        end
      end else if (t < HdrLen) begin
        field_shift_next = fs_shift;
        case (t[2:0])
          3'd1: begin
            if (field_shift[7:0] == CHAR_I && b == CHAR_I) begin
              order_big_next = 1'b0;
            end else if (field_shift[7:0] == CHAR_M && b == CHAR_M) begin
              order_big_next = 1'b1;
            end else begin
              flags_next[1] = 1'b1;
            end
          end
          3'd3: begin
            if (ord16(fs_shift[15:0], order_big) != MAGIC) begin
              flags_next[1] = 1'b1;
            end
          end
          3'd7:    ifd_offset_next = ord32(fs_shift, order_big);
          default: ;
        endcase
      end else if (!flags[1] && ifd_offset >= 32'(HDR_LEN)) begin
        if (t_ext == base) begin
          field_shift_next = {24'd0, b};
        end else if (t_ext == base + 35'd1) begin
          // Entry count read: fix the end of the directory
          entries_next   = cnt_new;
          end_pos_next   = base + 35'd2 + 35'({cnt_new, 3'b000}) + 35'({cnt_new, 2'b00});
          end_valid_next = 1'b1;
          rel_next       = 4'd0;
        end else if (end_valid) begin
          if (t_ext < end_pos) begin
            rel_next = (rel == 4'(ENTRY_LEN - 1)) ? 4'd0 : rel + 4'd1;
            if (rel < 4'd8) begin
              entry_fields_next = {entry_fields[55:0], b};
            end else begin
              field_shift_next = fs_shift;
              if (rel == 4'(ENTRY_LEN - 1)) begin
                if (tag == TAG_GPS) begin
                  flags_next[2] = 1'b1;
                end else if (tag == TAG_ORIENT && n_vals == 32'd1 && val_ok &&
                             val >= 32'd1 && val <= 32'd8) begin
                  found_orient_next = val[3:0];
                end
              end
            end
          end else if (t_ext < end_pos + 35'd4) begin
            field_shift_next = fs_shift;
            if (t_ext == end_pos + 35'd3 && fs_shift != 32'd0) begin
              flags_next[3] = 1'b1;
            end
          end
        end
      end
    end
  end

  // Judge the payload as it stands after this byte
  assign tlen     = pos_next - IdLen;
  assign tlen_ext = 35'(tlen);

  always_comb begin
    result = '0;
    if (pos_next < IdLen || flags_next[0]) begin
      result.status = STATUS_NOT_EXIF;
    end else begin
      result.status = STATUS_MALFORMED;
      if (tlen >= HdrLen && !flags_next[1]) begin
        result.order_mm = order_big_next;
        if (ifd_offset >= 32'(HDR_LEN) && base + 35'd2 <= tlen_ext &&
            {1'b0, entries} <= EntMax && end_valid && end_pos + 35'd4 <= tlen_ext) begin
          result.status       = STATUS_OK;
          result.valid_res    = 1'b1;
          result.orientation  = found_orient_next;
          result.has_gps      = flags_next[2];
          result.has_next_ifd = flags_next[3];
          result.ifd_entries  = entries[8:0];
        end
      end
    end
  end

  // State register; a last byte returns everything to its reset value
  always_ff @(posedge clk) begin
    if (rst || (fire && item.last_byte)) begin
      pos          <= '0;
      order_big    <= 1'b0;
      field_shift  <= '0;
      ifd_offset   <= '0;
      entries      <= '0;
      entry_fields <= '0;
      found_orient <= '0;
      flags        <= '0;
      end_pos      <= '0;
      end_valid    <= 1'b0;
      rel          <= '0;
    end else if (fire) begin
      pos          <= pos_next;
      order_big    <= order_big_next;
      field_shift  <= field_shift_next;
      ifd_offset   <= ifd_offset_next;
      entries      <= entries_next;
      entry_fields <= entry_fields_next;
      found_orient <= found_orient_next;
      flags        <= flags_next;
      end_pos      <= end_pos_next;
      end_valid    <= end_valid_next;
      rel          <= rel_next;
    end
  end

endmodule

>>> design/eios_out_reg.sv
module eios_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  eios_pkg::result_t result,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata   // status[1:0], valid_res, order_mm,
                                      // orientation[3:0], has_gps, has_next_ifd,
                                      // ifd_entries[8:0], zero pad
);
  import eios_pkg::*;

  result_t held;

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  // Pack lowest field first
  assign m_tdata = {5'd0, held.ifd_entries, held.has_next_ifd, held.has_gps,
                    held.orientation, held.order_mm, held.valid_res, held.status};

endmodule
